>>> rtl/rbsi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared widths, register indexes and item types for the ray/box slab test
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int NUM_AXES   = 3;
    localparam int NUM_LANES  = 2 * NUM_AXES;

    localparam int COORD_W    = 32;
    localparam int DIR_W      = 18;
    localparam int LEN_W      = 31;
    localparam int DIR_FRAC   = 16;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int DELTA_W    = 33;
    localparam int MAG_W      = 33;
    localparam int REM_W      = MAG_W + 2;
    localparam int SUM2_W     = COORD_W + 3;
    localparam int DOTP_W     = DIR_W + SUM2_W;
    localparam int DOT_W      = DOTP_W + 2;
    localparam int EF_W       = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int BOX_DATA_W = 2 * NUM_AXES * COORD_W;
    localparam int RES_DATA_W = 120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X   = 3'd0,
        CFG_ORIGIN_Y   = 3'd1,
        CFG_ORIGIN_Z   = 3'd2,
        CFG_DIR_X      = 3'd3,
        CFG_DIR_Y      = 3'd4,
        CFG_DIR_Z      = 3'd5,
        CFG_SEG_LENGTH = 3'd6
    } cfg_idx_t;

    typedef logic [NUM_AXES-1:0][COORD_W-1:0]  coord3_t;
    typedef logic [NUM_AXES-1:0][DIR_W-1:0]    dir3_t;
    typedef logic [NUM_AXES-1:0][DELTA_W-1:0]  delta3_t;
    typedef logic [NUM_LANES-1:0][MAG_W-1:0]   mag6_t;

    typedef struct packed {
        logic [NUM_LANES-1:0] neg;
        logic [NUM_LANES-1:0] sat;
        logic [NUM_AXES-1:0]  zero;
        logic [NUM_AXES-1:0]  interior;
        logic                 reject;
        delta3_t              delta;
    } slab_side_t;

endpackage
`default_nettype wire

>>> rtl/rbsi_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_front
// axis movement, slab distances, divider operands and behind-ray rejection
// ----------------------------------------------------------------------------
module rbsi_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  rbsi_pkg::coord3_t             box_min,
    input  rbsi_pkg::coord3_t             box_max,
    input  rbsi_pkg::coord3_t             origin,
    input  rbsi_pkg::dir3_t               dir,
    input  logic [rbsi_pkg::LEN_W-1:0]    seg_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rbsi_pkg::mag6_t               num,
    output rbsi_pkg::mag6_t               den,
    output rbsi_pkg::slab_side_t          side
);
    import rbsi_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;

    logic                                 mode1_reg;
    logic [NUM_AXES-1:0][DELTA_W-1:0]     delta1_reg, delta1_next;
    logic [NUM_AXES-1:0][DIFF_W-1:0]      dmin1_reg, dmin1_next;
    logic [NUM_AXES-1:0][DIFF_W-1:0]      dmax1_reg, dmax1_next;
    logic [NUM_AXES-1:0][SUM2_W-1:0]      s1_reg, s1_next;
    logic signed [DIR_W+LEN_W:0]          prod [NUM_AXES];

    logic                                 mode2_reg;
    mag6_t                                num2_reg, num2_next;
    mag6_t                                den2_reg, den2_next;
    slab_side_t                           side2_reg, side2_next;
    logic [NUM_AXES-1:0][DOTP_W-1:0]      dotp2_reg, dotp2_next;

    mag6_t                                num3_reg, den3_reg;
    slab_side_t                           side3_reg, side3_next;
    logic [DOT_W-1:0]                     dot;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // movement per axis, distances to both bounds, twice the centre minus twice the origin
    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            prod[a]        = $signed(dir[a]) * $signed({1'b0, seg_length});
            delta1_next[a] = DELTA_W'(prod[a] >>> DIR_FRAC);
            dmin1_next[a]  = DIFF_W'($signed(box_min[a])) - DIFF_W'($signed(origin[a]));
            dmax1_next[a]  = DIFF_W'($signed(box_max[a])) - DIFF_W'($signed(origin[a]));
            s1_next[a]     = SUM2_W'($signed(box_min[a])) + SUM2_W'($signed(box_max[a]))
                           - SUM2_W'($signed(origin[a])) - SUM2_W'($signed(origin[a]));
        end
    end

    // magnitudes, signs and flags for the divider
    always_comb begin
        logic signed [DELTA_W-1:0] dl;
        logic signed [DIFF_W-1:0]  dn;
        logic signed [DIFF_W-1:0]  dx;
        logic [MAG_W-1:0]          dabs;
        side2_next = '0;
        num2_next  = '0;
        den2_next  = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            dl   = delta1_reg[a];
            dn   = dmin1_reg[a];
            dx   = dmax1_reg[a];
            dabs = dl[DELTA_W-1] ? MAG_W'(-dl) : MAG_W'(dl);
            den2_next[2*a]   = dabs;
            den2_next[2*a+1] = dabs;
            num2_next[2*a]   = dn[DIFF_W-1] ? MAG_W'(-dn) : MAG_W'(dn);
            num2_next[2*a+1] = dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
            side2_next.neg[2*a]   = dn[DIFF_W-1] ^ dl[DELTA_W-1];
            side2_next.neg[2*a+1] = dx[DIFF_W-1] ^ dl[DELTA_W-1];
            side2_next.sat[2*a]   = {2'b00, num2_next[2*a]} >= {dabs, 2'b00};
            side2_next.sat[2*a+1] = {2'b00, num2_next[2*a+1]} >= {dabs, 2'b00};
            side2_next.zero[a]    = (dl == '0);
            side2_next.interior[a] = dn[DIFF_W-1] && !dx[DIFF_W-1] && (dx != '0);
            side2_next.delta[a]   = delta1_reg[a];
            dotp2_next[a]         = $signed(dir[a]) * $signed(s1_reg[a]);
        end
    end

    // direction dot centre offset
    always_comb begin
        dot = DOT_W'($signed(dotp2_reg[0])) + DOT_W'($signed(dotp2_reg[1]))
            + DOT_W'($signed(dotp2_reg[2]));
        side3_next        = side2_reg;
        side3_next.reject = !mode2_reg && dot[DOT_W-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            mode1_reg  <= mode;
            delta1_reg <= delta1_next;
            dmin1_reg  <= dmin1_next;
            dmax1_reg  <= dmax1_next;
            s1_reg     <= s1_next;
        end
        if (en2)
        begin
            mode2_reg <= mode1_reg;
            num2_reg  <= num2_next;
            den2_reg  <= den2_next;
            side2_reg <= side2_next;
            dotp2_reg <= dotp2_next;
        end
        if (en3)
        begin
            num3_reg  <= num2_reg;
            den3_reg  <= den2_reg;
            side3_reg <= side3_next;
        end
    end

    assign out_valid = v3_reg;
    assign num       = num3_reg;
    assign den       = den3_reg;
    assign side      = side3_reg;

endmodule
`default_nettype wire

>>> rtl/rbsi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_div
// six-lane restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module rbsi_div #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  rbsi_pkg::mag6_t                               num,
    input  rbsi_pkg::mag6_t                               den,
    input  rbsi_pkg::slab_side_t                          side_in,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [rbsi_pkg::NUM_LANES-1:0][FRAC_BITS+1:0] quo,
    output rbsi_pkg::slab_side_t                          side_out
);
    import rbsi_pkg::*;

    localparam int STAGES = FRAC_BITS + 2;
    localparam int Q_W    = FRAC_BITS + 2;

    logic [STAGES-1:0]                 v_reg;
    logic [STAGES-1:0]                 en;
    logic [NUM_LANES-1:0][Q_W-1:0]     q_reg   [STAGES];
    slab_side_t                        side_reg[STAGES];
    logic [NUM_LANES-1:0][REM_W-1:0]   rem_reg [STAGES-1];
    mag6_t                             den_reg [STAGES-1];

    assign in_ready = en[0];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [NUM_LANES-1:0][REM_W-1:0] rem_in;
        mag6_t                           den_in;
        logic [NUM_LANES-1:0][Q_W-1:0]   q_in;
        logic [NUM_LANES-1:0][Q_W-1:0]   q_out;
        logic [NUM_LANES-1:0]            cmp;
        slab_side_t                      side_k;
        logic                            v_in;

        if (k == 0) begin : g_first
            always_comb begin
                for (int l = 0; l < NUM_LANES; l++) begin
                    rem_in[l] = REM_W'(num[l]);
                end
            end
            assign den_in = den;
            assign q_in   = '0;
            assign side_k = side_in;
            assign v_in   = in_valid;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign q_in   = q_reg[k-1];
            assign side_k = side_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        if (k == STAGES - 1) begin : g_last_en
            assign en[k] = !v_reg[k] || out_ready;
        end else begin : g_mid_en
            assign en[k] = !v_reg[k] || en[k+1];
        end

        // compare against twice the divisor; once below four times it, rem stays so
        always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
                cmp[l]   = rem_in[l] >= {1'b0, den_in[l], 1'b0};
                q_out[l] = {q_in[l][Q_W-2:0], cmp[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                q_reg[k]    <= q_out;
                side_reg[k] <= side_k;
            end
        end

        if (k < STAGES - 1) begin : g_rem
            logic [NUM_LANES-1:0][REM_W-1:0] rem_out;

            always_comb begin
                logic [REM_W-1:0] rdiff;
                for (int l = 0; l < NUM_LANES; l++) begin
                    rdiff      = cmp[l] ? rem_in[l] - {1'b0, den_in[l], 1'b0} : rem_in[l];
                    rem_out[l] = {rdiff[REM_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[k])
                begin
                    rem_reg[k] <= rem_out;
                    den_reg[k] <= den_in;
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign quo       = q_reg[STAGES-1];
    assign side_out  = side_reg[STAGES-1];

endmodule
`default_nettype wire

>>> rtl/rbsi_clip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_clip
// signed slab fractions and clipping of the entry/exit interval per axis
// ----------------------------------------------------------------------------
module rbsi_clip #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [rbsi_pkg::NUM_LANES-1:0][FRAC_BITS+1:0] quo,
    input  rbsi_pkg::slab_side_t                          side,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic                                          hit,
    output logic [FRAC_BITS+2:0]                          lo,
    output rbsi_pkg::delta3_t                             delta
);
    import rbsi_pkg::*;

    localparam int Q_W    = FRAC_BITS + 2;
    localparam int F_W    = FRAC_BITS + 3;
    localparam int STAGES = NUM_AXES + 1;
    localparam logic [Q_W-1:0]        LIM = Q_W'(1) << (FRAC_BITS + 1);
    localparam logic signed [F_W-1:0] ONE = F_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic                           hit;
        logic [F_W-1:0]                 lo;
        logic [F_W-1:0]                 hi;
        logic [NUM_AXES-1:0][F_W-1:0]   fn;
        logic [NUM_AXES-1:0][F_W-1:0]   ff;
        logic [NUM_AXES-1:0]            zero;
        logic [NUM_AXES-1:0]            interior;
        delta3_t                        delta;
    } clip_stage_t;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] en;
    clip_stage_t       st_reg [STAGES];
    clip_stage_t       st_first;

    assign in_ready = en[0];

    // saturate, apply sign and order near/far per axis
    always_comb begin
        logic [Q_W-1:0]        r;
        logic signed [F_W-1:0] f [NUM_LANES];
        for (int l = 0; l < NUM_LANES; l++) begin
            r    = (side.sat[l] || quo[l] > LIM) ? LIM : quo[l];
            f[l] = side.neg[l] ? -F_W'({1'b0, r}) : F_W'({1'b0, r});
        end
        st_first          = '0;
        st_first.hit      = !side.reject;
        st_first.lo       = '0;
        st_first.hi       = ONE;
        st_first.zero     = side.zero;
        st_first.interior = side.interior;
        st_first.delta    = side.delta;
        for (int a = 0; a < NUM_AXES; a++) begin
            if (f[2*a] > f[2*a+1])
            begin
                st_first.fn[a] = f[2*a+1];
                st_first.ff[a] = f[2*a];
            end
            else
            begin
                st_first.fn[a] = f[2*a];
                st_first.ff[a] = f[2*a+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            st_reg[0] <= st_first;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_en
        if (k == STAGES - 1) begin : g_last
            assign en[k] = !v_reg[k] || out_ready;
        end else begin : g_mid
            assign en[k] = !v_reg[k] || en[k+1];
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        clip_stage_t nx;

        always_comb begin
            logic signed [F_W-1:0] fn;
            logic signed [F_W-1:0] ff;
            logic signed [F_W-1:0] lo_c;
            logic signed [F_W-1:0] hi_c;
            logic signed [F_W-1:0] lo_n;
            logic signed [F_W-1:0] hi_n;
            nx   = st_reg[a];
            fn   = st_reg[a].fn[a];
            ff   = st_reg[a].ff[a];
            lo_c = st_reg[a].lo;
            hi_c = st_reg[a].hi;
            lo_n = (fn > lo_c) ? fn : lo_c;
            hi_n = (ff < hi_c) ? ff : hi_c;
            if (st_reg[a].hit)
            begin
                if (st_reg[a].zero[a])
                begin
                    nx.hit = st_reg[a].interior[a];
                end
                else if (fn > hi_c || ff < lo_c)
                begin
                    nx.hit = 1'b0;
                end
                else
                begin
                    nx.lo  = lo_n;
                    nx.hi  = hi_n;
                    nx.hit = !(lo_n > hi_n || lo_n > ONE);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[a+1] <= 1'b0;
            end
            else if (en[a+1])
            begin
                v_reg[a+1] <= v_reg[a];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[a+1])
            begin
                st_reg[a+1] <= nx;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign hit       = st_reg[STAGES-1].hit;
    assign lo        = st_reg[STAGES-1].lo;
    assign delta     = st_reg[STAGES-1].delta;

endmodule
`default_nettype wire

>>> rtl/rbsi_point.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbsi_point
// entry point from movement times entry fraction, saturation, result register
// ----------------------------------------------------------------------------
module rbsi_point #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          hit_in,
    input  logic [FRAC_BITS+2:0]          lo,
    input  rbsi_pkg::delta3_t             delta,
    input  rbsi_pkg::coord3_t             origin,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic [rbsi_pkg::EF_W-1:0]     entry_fraction,
    output rbsi_pkg::coord3_t             point
);
    import rbsi_pkg::*;

    localparam int F_W    = FRAC_BITS + 3;
    localparam int PROD_W = DELTA_W + F_W;
    localparam int PT_W   = DELTA_W + 4;

    logic v1_reg, v2_reg;
    logic en1, en2;

    logic                        hit1_reg;
    logic [F_W-1:0]              lo1_reg;
    logic signed [PROD_W-1:0]    prod1_reg [NUM_AXES];
    logic signed [PROD_W-1:0]    prod1_next[NUM_AXES];

    logic                        hit2_reg;
    logic [EF_W-1:0]             ef2_reg, ef2_next;
    coord3_t                     pt2_reg, pt2_next;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            prod1_next[a] = $signed(delta[a]) * $signed(lo);
        end
    end

    // floor shift, add origin, clamp to 32 bits; zero on a miss
    always_comb begin
        logic [PT_W-1:0]       sh;
        logic [PT_W-1:0]       total;
        logic [FRAC_BITS+17:0] ef_wide;
        ef_wide  = {lo1_reg[F_W-2:0], {DIR_FRAC{1'b0}}} >> FRAC_BITS;
        ef2_next = hit1_reg ? EF_W'(ef_wide) : '0;
        pt2_next = '0;
        for (int a = 0; a < NUM_AXES; a++) begin
            sh    = PT_W'(prod1_reg[a] >>> FRAC_BITS);
            total = sh + PT_W'($signed(origin[a]));
            if (!hit1_reg)
            begin
                pt2_next[a] = '0;
            end
            else if (total[PT_W-1:COORD_W-1] == '0 || total[PT_W-1:COORD_W-1] == '1)
            begin
                pt2_next[a] = total[COORD_W-1:0];
            end
            else
            begin
                pt2_next[a] = total[PT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}}
                                            : {1'b0, {(COORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            hit1_reg  <= hit_in;
            lo1_reg   <= lo;
            prod1_reg <= prod1_next;
        end
        if (en2)
        begin
            hit2_reg <= hit1_reg;
            ef2_reg  <= ef2_next;
            pt2_reg  <= pt2_next;
        end
    end

    assign out_valid      = v2_reg;
    assign hit            = hit2_reg;
    assign entry_fraction = ef2_reg;
    assign point          = pt2_reg;

endmodule
`default_nettype wire

>>> rtl/ray_box_slab_intersect.sv
`timescale 1ns / 1ps
`default_nettype none
// FRAC_BITS + 11 register stages from accept to result; throughput: one item per cycle
// unless the output stalls, every stage holds one item in flight
// the divider sets the depth: one quotient bit per stage, FRAC_BITS + 2 stages
// a stalled output holds its item while upstream bubbles still fill
// reset clears all valid bits and loads origin 0, direction +x, length 1.0
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// fixed-point ray segment against axis-aligned box, slab method, pipelined
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
    parameter int FRAC_BITS = rbsi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rbsi_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [rbsi_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [rbsi_pkg::BOX_DATA_W-1:0]      s_tdata,
    // mode
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // entry_fraction, point_x, point_y, point_z, zero fill
    output logic [rbsi_pkg::RES_DATA_W-1:0]      m_tdata,
    // hit
    output logic                                 m_tuser
);
    import rbsi_pkg::*;

    coord3_t                origin_reg;
    dir3_t                  dir_reg;
    logic [LEN_W-1:0]       seg_reg;

    logic                   fr_valid, fr_ready;
    mag6_t                  fr_num, fr_den;
    slab_side_t             fr_side;

    logic                   dv_valid, dv_ready;
    logic [NUM_LANES-1:0][FRAC_BITS+1:0] dv_quo;
    slab_side_t             dv_side;

    logic                   cl_valid, cl_ready;
    logic                   cl_hit;
    logic [FRAC_BITS+2:0]   cl_lo;
    delta3_t                cl_delta;

    logic                   pt_hit;
    logic [EF_W-1:0]        pt_ef;
    coord3_t                pt_point;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_reg <= '0;
            dir_reg[0] <= DIR_W'(1 << DIR_FRAC);
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            seg_reg    <= LEN_W'(1 << DIR_FRAC);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_ORIGIN_X:   origin_reg[0] <= cfg_wdata;
                CFG_ORIGIN_Y:   origin_reg[1] <= cfg_wdata;
                CFG_ORIGIN_Z:   origin_reg[2] <= cfg_wdata;
                CFG_DIR_X:      dir_reg[0]    <= cfg_wdata[DIR_W-1:0];
                CFG_DIR_Y:      dir_reg[1]    <= cfg_wdata[DIR_W-1:0];
                CFG_DIR_Z:      dir_reg[2]    <= cfg_wdata[DIR_W-1:0];
                CFG_SEG_LENGTH: seg_reg       <= cfg_wdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    rbsi_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .mode       (s_tuser),
        .box_min    (s_tdata[NUM_AXES*COORD_W-1:0]),
        .box_max    (s_tdata[BOX_DATA_W-1:NUM_AXES*COORD_W]),
        .origin     (origin_reg),
        .dir        (dir_reg),
        .seg_length (seg_reg),
        .out_valid  (fr_valid),
        .out_ready  (fr_ready),
        .num        (fr_num),
        .den        (fr_den),
        .side       (fr_side)
    );

    rbsi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .num       (fr_num),
        .den       (fr_den),
        .side_in   (fr_side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .quo       (dv_quo),
        .side_out  (dv_side)
    );

    rbsi_clip #(
        .FRAC_BITS (FRAC_BITS)
    ) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .quo       (dv_quo),
        .side      (dv_side),
        .out_valid (cl_valid),
        .out_ready (cl_ready),
        .hit       (cl_hit),
        .lo        (cl_lo),
        .delta     (cl_delta)
    );

    rbsi_point #(
        .FRAC_BITS (FRAC_BITS)
    ) u_point (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (cl_valid),
        .in_ready       (cl_ready),
        .hit_in         (cl_hit),
        .lo             (cl_lo),
        .delta          (cl_delta),
        .origin         (origin_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .hit            (pt_hit),
        .entry_fraction (pt_ef),
        .point          (pt_point)
    );

    assign m_tuser = pt_hit;
    assign m_tdata = RES_DATA_W'({pt_point, pt_ef});

`ifndef NO_ASSERTIONS
    // an empty output stage means nothing upstream can be stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output stage empty");

    // a miss carries all-zero data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss item with nonzero data");

    // a hit enters within the segment
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata[EF_W-1:0] <= EF_W'(1 << DIR_FRAC))
        else $error("entry fraction above one");
`endif

endmodule
`default_nettype wire

>>> tb/sv/ray_box_slab_intersect_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_box_slab_intersect_test
// Drives boxes through the slab intersection block under several ray setups.
// Every result is checked against a behavioral prediction of hit, entry
// fraction and entry point. Both stream sides idle at random, but for the last random phases, which run at full rate.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect_test;
    import rbsi_pkg::*;

    typedef struct {
        bit               hit;
        logic [EF_W-1:0]  frac;
        logic [31:0]      pt [3];
    } hit_rec_t;

    class hit_scoreboard;
        longint   org [3];
        longint   dirv [3];
        longint   seg;
        hit_rec_t pending [$];
        int       errors;

        function void reset_ray();
            org = '{0, 0, 0};
            dirv = '{65536, 0, 0};
            seg = 65536;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [31:0] v);
            case (idx)
                CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z:
                    org[idx] = longint'(signed'(v));
                CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z:
                    dirv[idx - CFG_DIR_X] = longint'(signed'(v[17:0]));
                CFG_SEG_LENGTH: seg = longint'(v[30:0]);
                default: ;
            endcase
        endfunction

        function longint slab_frac(longint num, longint den);
            longint unsigned n, d, q;
            longint r;
            n = (num < 0) ? -num : num;
            d = (den < 0) ? -den : den;
            q = (n << 16) / d;
            r = (q > (64'd2 << 16)) ? (longint'(2) << 16) : longint'(q);
            return ((num < 0) != (den < 0)) ? -r : r;
        endfunction

        function void note_box(bit mode, logic [31:0] bmn [3], logic [31:0] bmx [3]);
            hit_rec_t e;
            longint mn [3], mx [3], delta [3];
            longint lo, hi, dot, fn, ff, t, p;
            bit hit;
            lo = 0;
            hi = 65536;
            hit = 1;
            dot = 0;
            for (int a = 0; a < 3; a++)
            begin
                mn[a] = longint'(signed'(bmn[a]));
                mx[a] = longint'(signed'(bmx[a]));
                delta[a] = (dirv[a] * seg) >>> 16;
                dot += dirv[a] * (mn[a] + mx[a] - 2 * org[a]);
            end
            e.hit = 0;
            e.frac = '0;
            e.pt = '{32'd0, 32'd0, 32'd0};
            if (mode == 0 && dot < 0)
                hit = 0;
            for (int a = 0; a < 3 && hit; a++)
            begin
                if (delta[a] == 0)
                begin
                    hit = org[a] > mn[a] && org[a] < mx[a];
                    continue;
                end
                fn = slab_frac(mn[a] - org[a], delta[a]);
                ff = slab_frac(mx[a] - org[a], delta[a]);
                if (fn > ff)
                begin
                    t = fn;
                    fn = ff;
                    ff = t;
                end
                if (fn > hi || ff < lo)
                begin
                    hit = 0;
                    continue;
                end
                if (fn > lo) lo = fn;
                if (ff < hi) hi = ff;
                if (lo > hi || lo > 65536) hit = 0;
            end
            if (hit)
            begin
                e.hit = 1;
                e.frac = lo[EF_W-1:0];
                for (int a = 0; a < 3; a++)
                begin
                    p = org[a] + ((delta[a] * lo) >>> 16);
                    if (p > 64'sh7fffffff) p = 64'sh7fffffff;
                    if (p < -64'sh80000000) p = -64'sh80000000;
                    e.pt[a] = p[31:0];
                end
            end
            pending.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h want %h", what, got, want);
            errors++;
        endtask

        task check_result(bit hit, logic [EF_W-1:0] frac, logic [31:0] pt [3]);
            hit_rec_t e;
            if (pending.size() == 0)
            begin
                report("unexpected item", 32'(hit), 0);
                return;
            end
            e = pending.pop_front();
            if (hit != e.hit) report("hit", 32'(hit), 32'(e.hit));
            if (frac != e.frac) report("entry_fraction", 32'(frac), 32'(e.frac));
            for (int a = 0; a < 3; a++)
                if (pt[a] !== e.pt[a]) report($sformatf("point[%0d]", a), pt[a], e.pt[a]);
        endtask
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [BOX_DATA_W-1:0] s_tdata = '0;
    logic                  s_tuser = 0;
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [RES_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    hit_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int cycles;

    ray_box_slab_intersect u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    always @(negedge clk)
        m_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        logic [31:0] pt [3];
        if (rst_n && m_tvalid && m_tready)
        begin
            pt = '{m_tdata[48:17], m_tdata[80:49], m_tdata[112:81]};
            sb.check_result(m_tuser, m_tdata[16:0], pt);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task write_reg(cfg_idx_t idx, logic [31:0] v);
        cfg_we <= 1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we <= 0;
        @(negedge clk);
    endtask

    task set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                 logic [17:0] dx, logic [17:0] dy, logic [17:0] dz, logic [30:0] len);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_DIR_X, {14'd0, dx});
        write_reg(CFG_DIR_Y, {14'd0, dy});
        write_reg(CFG_DIR_Z, {14'd0, dz});
        write_reg(CFG_SEG_LENGTH, {1'b0, len});
    endtask

    task send_box(bit mode, logic [31:0] mn [3], logic [31:0] mx [3]);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= mode;
        s_tdata <= {mx[2], mx[1], mx[0], mn[2], mn[1], mn[0]};
        do @(posedge clk); while (!s_tready);
        sb.note_box(mode, mn, mx);
        @(negedge clk);
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // box around a point on the ray anywhere up to past the segment end, or plain noise per axis
    task send_random();
        logic [31:0] mn [3], mx [3];
        longint c, h, f;
        f = $urandom_range(90000);
        for (int a = 0; a < 3; a++)
        begin
            if ($urandom_range(9) < 2)
            begin
                mn[a] = $urandom;
                mx[a] = $urandom;
            end
            else
            begin
                c = sb.org[a] + (((sb.dirv[a] * sb.seg) >>> 16) * f >>> 16)
                    + longint'($urandom_range(4000)) - 2000;
                h = longint'($urandom) >> $urandom_range(31);
                mn[a] = 32'(c - h);
                mx[a] = 32'(c + (longint'($urandom) >> $urandom_range(31)));
                if ($urandom_range(19) == 0) mx[a] = 32'(c - h - 1);
            end
        end
        send_box($urandom_range(1), mn, mx);
    endtask

    task send_plain(bit mode, int x0, int y0, int z0, int x1, int y1, int z1);
        logic [31:0] mn [3], mx [3];
        mn = '{x0, y0, z0};
        mx = '{x1, y1, z1};
        send_box(mode, mn, mx);
    endtask

    initial
    begin
        sb = new();
        sb.reset_ray();
        send_idle_pct = 12;
        recv_idle_pct = 61;
        repeat (5) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        send_plain(0, 16384, -65536, -65536, 32768, 65536, 65536);
        send_plain(1, 16384, -65536, -65536, 32768, 65536, 65536);
        send_plain(0, -131072, -65536, -65536, -65536, 65536, 65536);
        send_plain(1, -131072, -65536, -65536, -65536, 65536, 65536);
        send_plain(1, 16384, 0, -65536, 32768, 65536, 65536);
        send_plain(1, 16384, -65536, -65536, 32768, 0, 65536);
        send_plain(1, 16384, -1, -1, 32768, 1, 1);
        send_plain(1, 32768, -65536, -65536, 16384, 65536, 65536);
        send_plain(1, -65536, -65536, -65536, 0, 65536, 65536);
        send_plain(1, 65536, -65536, -65536, 131072, 65536, 65536);
        send_plain(0, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_plain(1, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h80000000, 32'h80000000, 32'h80000000);
        send_plain(1, -1, -1, -1, 0, 0, 0);
        send_plain(0, 65535, -65536, -65536, 200000, 65536, 65536);
        drain();

        set_ray(32'h7fffffff, 32'h80000000, 0, 18'h10000, 18'h30000, 0, 31'h7fffffff);
        send_plain(0, 32'h7ffffff0, 32'h80000000, -1, 32'h7fffffff, 32'h80000100, 1);
        send_plain(1, 32'h80000000, 32'h80000000, -1, 32'h7fffffff, 32'h7fffffff, 1);
        send_plain(1, 32'h7fff0000, 32'h80000000, 0, 32'h7fffffff, 32'h7fffffff, 1);
        send_plain(0, 0, 0, -1, 1, 1, 1);
        send_plain(1, 32'h80000000, 32'h80000010, -5, 32'h80000100, 32'h80000100, 5);
        send_plain(1, 32'h7fffffff, 32'h7fffffff, -5, 32'h80000000, 32'h80000000, 5);
        drain();

        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: set_ray(0, 0, 0, 18'h10000, 0, 0, 31'h10000);
                1: set_ray($urandom, $urandom, $urandom, 18'h0b505, 18'h0b505, 0, 31'h80000);
                2: set_ray($urandom >> 4, 0, 32'h80000000, 18'h30000, 0, 18'h0, 0);
                3: set_ray(0, 32'h7fffffff, 0, 18'h093cd, 18'h36c32, 18'h093cd, 31'h7fffffff);
                4: set_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                5: set_ray(32'h12345, 32'hfff00000, 32'h10000, 0, 0, 18'h30000, 31'h4000000);
                default: set_ray(0, 0, 0, 18'h2ffff, 18'h1ffff, 18'h10001, $urandom);
            endcase
            send_idle_pct = (ph < 2) ? 12 : (ph < 4) ? 61 : 0;
            recv_idle_pct = (ph < 2) ? 61 : (ph < 4) ? 12 : 0;
            for (int i = 0; i < 90; i++)
            begin
                send_random();
                if (i == 45 && ph == 1)
                begin
                    s_tvalid <= 0;
                    while (sb.pending.size() != 0) @(negedge clk);
                end
            end
            drain();
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
